// ----- sv/p2ba_pkg.sv -----
package p2ba_pkg;

  localparam int unsigned MIN_BLOCK_BYTES_DEF = 32;
  localparam int unsigned NUM_CLASSES_DEF     = 15;
  localparam int unsigned POOL_BYTES_DEF      = 2097152;

  localparam int unsigned CLASS_W    = 4;
  localparam int unsigned MAXB_W     = 20;
  localparam int unsigned HDR_W      = 7;
  localparam int unsigned LEN_W      = 21;
  localparam int unsigned CLAMP_LOW  = 64;
  localparam int unsigned CLAMP_HIGH = 512 * 1024;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERSIZE = 2'd1;
  localparam logic [1:0] ST_NOMEM    = 2'd2;
  localparam logic [1:0] ST_BADFREE  = 2'd3;

  localparam logic REG_MAX_ALLOC = 1'b0;
  localparam logic REG_HEADER    = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_POP,
    S_SPLIT,
    S_FCHK
  } state_e;

  // Highest class whose block fits both the class count and the pool.
  function automatic int unsigned cap_class(int unsigned min_b, int unsigned num_c,
                                            int unsigned pool_b);
    int unsigned c;
    c = num_c - 1;
    while (c > 0 && (min_b << c) > pool_b) c = c - 1;
    return c;
  endfunction

endpackage

// ----- sv/power_of_two_block_allocator.sv -----
// Channel   | Dir | Handshake                     | Payload (low bit up)
// s_axis    | in  | s_axis_tvalid / s_axis_tready | opcode, req_bytes, free_addr
// m_axis    | out | m_axis_tvalid / m_axis_tready | status, block_addr, size_class,
//           |     |                               | bytes_in_use
// cfg       | in  | cfg_we_i                      | cfg_idx_i, cfg_data_i
//
// One item at a time. Allocate: accept, decode, pop (if a list fits), a split per halving
// (up to the top class), finish; free: accept, decode, check; oversize, out of memory,
// misaligned free, others: accept, decode. A step does at most one unit table access.
// Reset and release sweep the unit table, one entry a cycle,
// with s_axis_tready low; the release result goes out first.
// A result waits in the output register; a stalled m_axis holds the finishing step.
module power_of_two_block_allocator #(
  parameter int unsigned MIN_BLOCK_BYTES = p2ba_pkg::MIN_BLOCK_BYTES_DEF,
  parameter int unsigned NUM_CLASSES     = p2ba_pkg::NUM_CLASSES_DEF,
  parameter int unsigned POOL_BYTES      = p2ba_pkg::POOL_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // opcode[1:0], req_bytes[21:2], free_addr[42:22]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // status[1:0], block_addr[22:2], size_class[26:23],
                                      // bytes_in_use[48:27]
);

  localparam int unsigned MIN_SHIFT  = $clog2(MIN_BLOCK_BYTES);
  localparam int unsigned UNIT_COUNT = POOL_BYTES / MIN_BLOCK_BYTES;
  localparam int unsigned UW         = $clog2(UNIT_COUNT);
  localparam int unsigned TW         = $clog2(POOL_BYTES) + 1;
  localparam int unsigned CLW        = p2ba_pkg::CLASS_W;
  localparam int unsigned CIW        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned CAP        = p2ba_pkg::cap_class(MIN_BLOCK_BYTES, NUM_CLASSES,
                                                           POOL_BYTES);
  localparam int unsigned WORD_W     = 1 + CLW + 1 + UW;

  // unit table word: alloc | class | link valid | link
  logic [WORD_W-1:0] mem [UNIT_COUNT];
  logic              mem_we, mem_re;
  logic [UW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata_q;

  p2ba_pkg::state_e state_q, state_d;
  logic [p2ba_pkg::MAXB_W-1:0] cfg_max_q;
  logic [p2ba_pkg::HDR_W-1:0]  cfg_hdr_q;
  logic [CLW-1:0]  maxc_q, maxc_d;
  logic [1:0]      op_q, op_d;
  logic [19:0]     req_q, req_d;
  logic [20:0]     faddr_q, faddr_d;
  logic [CLW-1:0]  cls_q, cls_d, idx_q, idx_d;
  logic [UW-1:0]   unit_q, unit_d, clr_q, clr_d;
  logic [TW-1:0]   trunk_q, trunk_d, used_q, used_d;
  logic [UW-1:0]   head_q [NUM_CLASSES];
  logic [UW-1:0]   head_d [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] ne_q, ne_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [20:0]     out_addr_q, out_addr_d;
  logic [CLW-1:0]  out_cls_q, out_cls_d;
  logic [21:0]     out_used_q, out_used_d;

  // largest class from the registers
  logic [p2ba_pkg::LEN_W-1:0] len_raw, len_c;
  logic [4:0]                 len_cnt;
  always_comb begin
    len_raw = p2ba_pkg::LEN_W'(cfg_max_q) + p2ba_pkg::LEN_W'(cfg_hdr_q);
    len_c   = len_raw;
    if (len_raw < p2ba_pkg::LEN_W'(p2ba_pkg::CLAMP_LOW))  len_c = p2ba_pkg::LEN_W'(p2ba_pkg::CLAMP_LOW);
    if (len_raw > p2ba_pkg::LEN_W'(p2ba_pkg::CLAMP_HIGH)) len_c = p2ba_pkg::LEN_W'(p2ba_pkg::CLAMP_HIGH);
    len_cnt = '0;
    for (int j = 0; j < p2ba_pkg::LEN_W; j++) begin
      if ((len_c >> j) > p2ba_pkg::LEN_W'(MIN_BLOCK_BYTES)) len_cnt = len_cnt + 5'd1;
    end
    maxc_d = (len_cnt > 5'(CAP)) ? CLW'(CAP) : len_cnt[CLW-1:0];
  end

  logic           out_free;
  logic [TW-1:0]  maxsz;
  logic [20:0]    size;
  logic [CLW-1:0] cls_c, fidx, pc, fcls;
  logic           found, misaligned, in_range;
  logic [UW-1:0]  paddr, funit;
  logic [TW-1:0]  bsz, add_sz;

  always_comb begin
    out_free   = !out_valid_q || m_axis_tready;
    maxsz      = TW'(MIN_BLOCK_BYTES) << maxc_q;
    size       = 21'(req_q) + 21'(cfg_hdr_q);
    cls_c      = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (CLW'(c) < maxc_q && (32'(MIN_BLOCK_BYTES) << c) < 32'(size)) cls_c = cls_c + 1'b1;
    end
    found = 1'b0;
    fidx  = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (CLW'(c) >= cls_c && CLW'(c) <= maxc_q && ne_q[c]) begin
        found = 1'b1;
        fidx  = CLW'(c);
      end
    end
    misaligned = faddr_q[MIN_SHIFT-1:0] != '0;
    in_range   = 32'(faddr_q >> MIN_SHIFT) < 32'(UNIT_COUNT);
    funit      = UW'(faddr_q >> MIN_SHIFT);
    pc         = idx_q - 1'b1;
    paddr      = unit_q + (UW'(1) << pc);
    fcls       = mem_rdata_q[WORD_W-2 -: CLW];
    if (5'(fcls) >= 5'(NUM_CLASSES)) fcls = CLW'(NUM_CLASSES - 1);
    bsz        = TW'(MIN_BLOCK_BYTES) << fcls;
    add_sz     = TW'(MIN_BLOCK_BYTES) << cls_q;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    req_d        = req_q;
    faddr_d      = faddr_q;
    cls_d        = cls_q;
    idx_d        = idx_q;
    unit_d       = unit_q;
    clr_d        = clr_q;
    trunk_d      = trunk_q;
    used_d       = used_q;
    head_d       = head_q;
    ne_d         = ne_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_cls_d    = out_cls_q;
    out_used_d   = out_used_q;
    s_axis_tready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    case (state_q)
      p2ba_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == UW'(UNIT_COUNT - 1)) state_d = p2ba_pkg::S_IDLE;
      end
      p2ba_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op_d    = s_axis_tdata[1:0];
          req_d   = s_axis_tdata[21:2];
          faddr_d = s_axis_tdata[42:22];
          state_d = p2ba_pkg::S_DEC;
        end
      end
      p2ba_pkg::S_DEC: begin
        case (op_q)
          p2ba_pkg::OP_ALLOC: begin
            if (32'(size) > 32'(maxsz)) begin
              if (out_free) begin
                out_valid_d  = 1'b1;
                out_status_d = p2ba_pkg::ST_OVERSIZE;
                out_addr_d   = '0;
                out_cls_d    = '0;
                out_used_d   = 22'(used_q);
                state_d      = p2ba_pkg::S_IDLE;
              end
            end else if (found) begin
              mem_re    = 1'b1;
              mem_raddr = head_q[fidx[CIW-1:0]];
              unit_d    = head_q[fidx[CIW-1:0]];
              idx_d     = fidx;
              cls_d     = cls_c;
              state_d   = p2ba_pkg::S_POP;
            end else if (trunk_q > TW'(POOL_BYTES) - maxsz) begin
              if (out_free) begin
                out_valid_d  = 1'b1;
                out_status_d = p2ba_pkg::ST_NOMEM;
                out_addr_d   = '0;
                out_cls_d    = '0;
                out_used_d   = 22'(used_q);
                state_d      = p2ba_pkg::S_IDLE;
              end
            end else begin
              // carve a fresh trunk of the top class
              unit_d  = UW'(trunk_q >> MIN_SHIFT);
              trunk_d = trunk_q + maxsz;
              idx_d   = maxc_q;
              cls_d   = cls_c;
              state_d = p2ba_pkg::S_SPLIT;
            end
          end
          p2ba_pkg::OP_FREE: begin
            if (misaligned || !in_range) begin
              if (out_free) begin
                out_valid_d  = 1'b1;
                out_status_d = p2ba_pkg::ST_BADFREE;
                out_addr_d   = '0;
                out_cls_d    = '0;
                out_used_d   = 22'(used_q);
                state_d      = p2ba_pkg::S_IDLE;
              end
            end else begin
              mem_re    = 1'b1;
              mem_raddr = funit;
              unit_d    = funit;
              state_d   = p2ba_pkg::S_FCHK;
            end
          end
          p2ba_pkg::OP_RELEASE: begin
            if (out_free) begin
              ne_d         = '0;
              trunk_d      = '0;
              used_d       = '0;
              out_valid_d  = 1'b1;
              out_status_d = p2ba_pkg::ST_OK;
              out_addr_d   = '0;
              out_cls_d    = '0;
              out_used_d   = '0;
              clr_d        = '0;
              state_d      = p2ba_pkg::S_CLEAR;
            end
          end
          default: begin
            if (out_free) begin
              out_valid_d  = 1'b1;
              out_status_d = p2ba_pkg::ST_OK;
              out_addr_d   = '0;
              out_cls_d    = '0;
              out_used_d   = 22'(used_q);
              state_d      = p2ba_pkg::S_IDLE;
            end
          end
        endcase
      end
      p2ba_pkg::S_POP: begin
        if (mem_rdata_q[UW]) begin
          head_d[idx_q[CIW-1:0]] = mem_rdata_q[UW-1:0];
        end else begin
          ne_d[idx_q[CIW-1:0]] = 1'b0;
        end
        state_d = p2ba_pkg::S_SPLIT;
      end
      p2ba_pkg::S_SPLIT: begin
        if (idx_q > cls_q) begin
          // push the upper half onto the next class down
          mem_we    = 1'b1;
          mem_waddr = paddr;
          mem_wdata = {1'b0, pc, ne_q[pc[CIW-1:0]], head_q[pc[CIW-1:0]]};
          head_d[pc[CIW-1:0]] = paddr;
          ne_d[pc[CIW-1:0]]   = 1'b1;
          idx_d     = pc;
        end else if (out_free) begin
          mem_we       = 1'b1;
          mem_waddr    = unit_q;
          mem_wdata    = {1'b1, cls_q, 1'b0, UW'(0)};
          used_d       = used_q + add_sz;
          out_valid_d  = 1'b1;
          out_status_d = p2ba_pkg::ST_OK;
          out_addr_d   = 21'(32'(unit_q) << MIN_SHIFT);
          out_cls_d    = cls_q;
          out_used_d   = 22'(used_q + add_sz);
          state_d      = p2ba_pkg::S_IDLE;
        end
      end
      p2ba_pkg::S_FCHK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_addr_d  = '0;
          state_d     = p2ba_pkg::S_IDLE;
          if (!mem_rdata_q[WORD_W-1]) begin
            out_status_d = p2ba_pkg::ST_BADFREE;
            out_cls_d    = '0;
            out_used_d   = 22'(used_q);
          end else begin
            mem_we    = 1'b1;
            mem_waddr = unit_q;
            mem_wdata = {1'b0, fcls, ne_q[fcls[CIW-1:0]], head_q[fcls[CIW-1:0]]};
            head_d[fcls[CIW-1:0]] = unit_q;
            ne_d[fcls[CIW-1:0]]   = 1'b1;
            used_d       = (used_q >= bsz) ? used_q - bsz : '0;
            out_status_d = p2ba_pkg::ST_OK;
            out_cls_d    = fcls;
            out_used_d   = 22'((used_q >= bsz) ? used_q - bsz : '0);
          end
        end
      end
      default: state_d = p2ba_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= p2ba_pkg::S_CLEAR;
      cfg_max_q   <= p2ba_pkg::MAXB_W'(65536);
      cfg_hdr_q   <= p2ba_pkg::HDR_W'(16);
      maxc_q      <= '0;
      clr_q       <= '0;
      trunk_q     <= '0;
      used_q      <= '0;
      ne_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      maxc_q      <= maxc_d;
      clr_q       <= clr_d;
      trunk_q     <= trunk_d;
      used_q      <= used_d;
      ne_q        <= ne_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i[0])
          p2ba_pkg::REG_MAX_ALLOC: cfg_max_q <= cfg_data_i;
          p2ba_pkg::REG_HEADER:    cfg_hdr_q <= cfg_data_i[p2ba_pkg::HDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_q        <= req_d;
    faddr_q      <= faddr_d;
    cls_q        <= cls_d;
    idx_q        <= idx_d;
    unit_q       <= unit_d;
    head_q       <= head_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_cls_q    <= out_cls_d;
    out_used_q   <= out_used_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_used_q, out_cls_q, out_addr_q, out_status_q};

`ifndef SYNTHESIS
  a_split_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == p2ba_pkg::S_SPLIT |-> cls_q <= idx_q)
    else $error("split index below target class");

  a_pop_after_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == p2ba_pkg::S_POP |-> $past(state_q) == p2ba_pkg::S_DEC)
    else $error("pop without a table read");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_status_q != p2ba_pkg::ST_OK |-> out_addr_q == '0 && out_cls_q == '0)
    else $error("error result carries address or class");

  a_trunk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trunk_q <= TW'(POOL_BYTES))
    else $error("trunk fill beyond pool");

  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == p2ba_pkg::S_DEC)
    else $error("accepted item not decoded");
`endif

endmodule

// ----- tb/sv/tb_power_of_two_block_allocator.sv -----
module tb_power_of_two_block_allocator;

  localparam int unsigned MIN_B      = p2ba_pkg::MIN_BLOCK_BYTES_DEF;
  localparam int unsigned NUM_C      = p2ba_pkg::NUM_CLASSES_DEF;
  localparam int unsigned POOL_B     = p2ba_pkg::POOL_BYTES_DEF;
  localparam int unsigned UNITS      = POOL_B / MIN_B;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int unsigned IDLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  status;
    logic [20:0] block_addr;
    logic [3:0]  size_class;
    logic [21:0] in_use;
  } alloc_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [19:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // opcode[1:0], req_bytes[21:2], free_addr[42:22]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;   // status[1:0], block_addr[22:2], size_class[26:23],
                               // bytes_in_use[48:27]

  power_of_two_block_allocator DUT (.*);

  // Shadow allocator state
  logic [19:0] max_bytes_q;
  logic [6:0]  hdr_bytes_q;
  logic [15:0] head_q [NUM_C];
  logic        nonempty_q [NUM_C];
  logic [16:0] next_link [UNITS];
  logic [3:0]  block_cls [UNITS];
  logic        block_live [UNITS];
  int unsigned carved_bytes;
  int unsigned used_bytes;

  alloc_result_t pending_results [$];
  logic [20:0]   live_addrs [$];
  int            mismatches = 0;
  int            burst_left;
  int            stall_mode = 0;
  int            stall_cnt = 0;
  int            quiet_cycles = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned top_class();
    int unsigned len;
    int unsigned c;
    len = 32'(max_bytes_q) + 32'(hdr_bytes_q);
    c = 0;
    if (len < p2ba_pkg::CLAMP_LOW) len = p2ba_pkg::CLAMP_LOW;
    if (len > p2ba_pkg::CLAMP_HIGH) len = p2ba_pkg::CLAMP_HIGH;
    while (len > MIN_B) begin
      c++;
      len = len / 2;
    end
    if (c > NUM_C - 1) c = NUM_C - 1;
    while (c > 0 && (MIN_B << c) > POOL_B) c--;
    return c;
  endfunction

  task automatic push_free(input int unsigned c, input int unsigned unit);
    if (c >= NUM_C || unit >= UNITS) return;
    next_link[unit] = nonempty_q[c] ? {1'b1, head_q[c]} : 17'd0;
    head_q[c] = unit[15:0];
    nonempty_q[c] = 1'b1;
    block_cls[unit] = c[3:0];
  endtask

  task automatic pop_free(input int unsigned c, output int unsigned unit);
    logic [16:0] nxt;
    unit = 32'(head_q[c]);
    nxt = next_link[unit];
    if (nxt[16]) begin
      head_q[c] = nxt[15:0];
    end else begin
      nonempty_q[c] = 1'b0;
      head_q[c] = '0;
    end
  endtask

  task automatic clear_pool();
    for (int k = 0; k < NUM_C; k++) begin
      head_q[k] = '0;
      nonempty_q[k] = 1'b0;
    end
    for (int k = 0; k < UNITS; k++) block_live[k] = 1'b0;
    carved_bytes = 0;
    used_bytes = 0;
    live_addrs.delete();
  endtask

  task automatic predict_step(input logic [1:0] op, input logic [19:0] req,
                              input logic [20:0] faddr, output alloc_result_t r);
    int unsigned need, maxc, maxsz, c, i, unit, bsz;
    r = '0;
    if (op == p2ba_pkg::OP_ALLOC) begin
      need = 32'(req) + 32'(hdr_bytes_q);
      maxc = top_class();
      maxsz = MIN_B << maxc;
      if (need > maxsz) begin
        r.status = p2ba_pkg::ST_OVERSIZE;
      end else begin
        c = 0;
        while (c < maxc && (MIN_B << c) < need) c++;
        i = c;
        while (i < maxc && !nonempty_q[i]) i++;
        if (nonempty_q[i]) begin
          pop_free(i, unit);
        end else if (carved_bytes > POOL_B - maxsz) begin
          r.status = p2ba_pkg::ST_NOMEM;
        end else begin
          unit = carved_bytes / MIN_B;
          carved_bytes += maxsz;
          i = maxc;
        end
        if (r.status != p2ba_pkg::ST_NOMEM) begin
          // hand the upper halves back while splitting down
          while (i > c) begin
            i--;
            push_free(i, unit + (1 << i));
          end
          block_live[unit] = 1'b1;
          block_cls[unit] = c[3:0];
          used_bytes += MIN_B << c;
          r.block_addr = 21'(unit * MIN_B);
          r.size_class = c[3:0];
          live_addrs.push_back(r.block_addr);
        end
      end
    end else if (op == p2ba_pkg::OP_FREE) begin
      unit = faddr / MIN_B;
      if (faddr % MIN_B != 0 || unit >= UNITS || !block_live[unit]) begin
        r.status = p2ba_pkg::ST_BADFREE;
      end else begin
        c = 32'(block_cls[unit]);
        if (c >= NUM_C) c = NUM_C - 1;
        bsz = MIN_B << c;
        block_live[unit] = 1'b0;
        used_bytes = (used_bytes >= bsz) ? used_bytes - bsz : 0;
        push_free(c, unit);
        r.size_class = c[3:0];
        foreach (live_addrs[k]) begin
          if (live_addrs[k] == faddr) begin
            live_addrs.delete(k);
            break;
          end
        end
      end
    end else if (op == p2ba_pkg::OP_RELEASE) begin
      clear_pool();
    end
    r.in_use = used_bytes[21:0];
  endtask

  task automatic send_item(input logic [1:0] op, input logic [19:0] req,
                           input logic [20:0] faddr);
    alloc_result_t r;
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {5'd0, faddr, req, op};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_step(op, req, faddr, r);
    pending_results.push_back(r);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0 || !s_axis_tready) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [19:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    if (idx == p2ba_pkg::REG_MAX_ALLOC) max_bytes_q = val;
    else hdr_bytes_q = val[6:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [19:0] req;
    pick = $urandom_range(0, 99);
    if (pick < 52) begin
      case ($urandom_range(0, 3))
        0: req = 20'($urandom_range(0, 64));
        1: req = 20'($urandom_range(0, 4096));
        2: req = 20'($urandom_range(0, max_bytes_q + 64));
        default: req = 20'($urandom);
      endcase
      send_item(p2ba_pkg::OP_ALLOC, req, 21'($urandom));
    end else if (pick < 95) begin
      if (live_addrs.size() != 0 && $urandom_range(0, 9) < 8)
        send_item(p2ba_pkg::OP_FREE, 20'($urandom),
                  live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
      else
        send_item(p2ba_pkg::OP_FREE, 20'($urandom), 21'($urandom));
    end else begin
      send_item(OP_UNUSED, 20'($urandom), 21'($urandom));
    end
  endtask

  task automatic test_directed();
    send_item(p2ba_pkg::OP_ALLOC, 20'd0, 21'd0);
    send_item(p2ba_pkg::OP_ALLOC, 20'hFFFFF, 21'h1FFFFF);
    send_item(p2ba_pkg::OP_ALLOC, 20'd65536, 21'd0);
    send_item(p2ba_pkg::OP_ALLOC, 20'd65537, 21'd0);
    send_item(p2ba_pkg::OP_FREE, 20'd0, live_addrs[0]);
    send_item(p2ba_pkg::OP_FREE, 20'd0, 21'd0);
    send_item(p2ba_pkg::OP_FREE, 20'd0, 21'd1);
    send_item(p2ba_pkg::OP_FREE, 20'd0, 21'h1FFFFF);
    send_item(p2ba_pkg::OP_FREE, 20'd0, 21'h1FFFE0);
    send_item(OP_UNUSED, 20'hFFFFF, 21'h1FFFFF);
    // exhaust the pool with top-class blocks
    repeat (40) send_item(p2ba_pkg::OP_ALLOC, 20'd65520, 21'd0);
    send_item(p2ba_pkg::OP_RELEASE, 20'd0, 21'd0);
  endtask

  task automatic test_settings(input logic [19:0] max_b, input logic [6:0] hdr, input int n);
    wait_drained();
    write_reg(p2ba_pkg::REG_MAX_ALLOC, max_b);
    write_reg(p2ba_pkg::REG_HEADER, {13'd0, hdr});
    repeat (n) send_random();
  endtask

  task automatic test_drain_pause();
    repeat (40) send_random();
    wait_drained();
    repeat (40) send_random();
    send_item(p2ba_pkg::OP_RELEASE, 20'hFFFFF, 21'h1FFFFF);
  endtask

  // receiver: phases of full speed and of random stalls
  always @(negedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_cnt <= $urandom_range(16, 128);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    m_axis_tready <= (stall_mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    alloc_result_t want;
    alloc_result_t got;
    got = '{m_axis_tdata[1:0], m_axis_tdata[22:2], m_axis_tdata[26:23], m_axis_tdata[48:27]};
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("tb_power_of_two_block_allocator: errors");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    burst_left = 0;
    max_bytes_q = 20'd65536;
    hdr_bytes_q = 7'd16;
    clear_pool();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    repeat (200) send_random();
    test_settings(20'd0, 7'd0, 220);
    test_settings(20'd524288, 7'd64, 220);
    test_settings(20'hFFFFF, 7'h7F, 220);
    test_settings(20'd1000, 7'd33, 220);
    test_settings(20'($urandom_range(0, 524288)), 7'($urandom_range(0, 64)), 220);
    test_drain_pause();
    test_settings(20'd65536, 7'd16, 220);

    wait_drained();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_power_of_two_block_allocator: clean");
    else
      $display("tb_power_of_two_block_allocator: errors");
    $finish;
  end

endmodule
